// File: rtl/core/jsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_ESC = 2'd1;
  localparam logic [1:0] ST_BAD_UNI = 2'd2;

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_ESCAPE,
    MODE_HEX
  } mode_t;

  typedef enum logic [1:0] {
    CMD_BYTE,
    CMD_CP,
    CMD_ERR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [15:0] data;
    logic [1:0]  status;
    logic        last;
  } cmd_t;

endpackage

// File: rtl/core/jsu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_front
// Escape parser: tracks escape state per byte and issues one command per
// completed character or error.
// ----------------------------------------------------------------------------
module jsu_front
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       push,
  output cmd_t       cmd
);

  mode_t       mode, mode_next;
  logic [1:0]  hex_count, hex_count_next;
  logic [15:0] code_point, code_point_next;
  logic        discarding, discarding_next;

  logic        is_hex;
  logic [3:0]  nib;
  logic [15:0] cp_shift;
  logic        fail;
  logic [1:0]  fail_code;

  always_comb begin
    is_hex = 1'b1;
    nib    = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      nib = in_byte[3:0];
    end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                 (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
      nib = in_byte[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
  end

  assign cp_shift = {code_point[11:0], nib};

  always_comb begin
    mode_next       = mode;
    hex_count_next  = hex_count;
    code_point_next = code_point;
    discarding_next = discarding;
    push            = 1'b0;
    cmd             = '{kind: CMD_BYTE, data: 16'd0, status: ST_OK, last: in_last};
    fail            = 1'b0;
    fail_code       = ST_OK;
    if (accept) begin
      if (discarding) begin
        if (in_last) begin
          discarding_next = 1'b0;
          mode_next       = MODE_NORMAL;
          hex_count_next  = 2'd0;
          code_point_next = 16'd0;
        end
      end else begin
        case (mode)
          MODE_ESCAPE: begin
            mode_next = MODE_NORMAL;
            push      = 1'b1;
            case (in_byte)
              8'h5C, 8'h22, 8'h2F: cmd.data = {8'd0, in_byte};
              8'h62: cmd.data = 16'h0008;
              8'h66: cmd.data = 16'h000C;
              8'h6E: cmd.data = 16'h000A;
              8'h72: cmd.data = 16'h000D;
              8'h74: cmd.data = 16'h0009;
              8'h75: begin
                push = 1'b0;
                if (in_last) begin
                  fail      = 1'b1;
                  fail_code = ST_BAD_UNI;
                end else begin
                  mode_next       = MODE_HEX;
                  hex_count_next  = 2'd0;
                  code_point_next = 16'd0;
                end
              end
              default: begin
                push      = 1'b0;
                fail      = 1'b1;
                fail_code = ST_BAD_ESC;
              end
            endcase
          end
          MODE_HEX: begin
            if (!is_hex) begin
              fail      = 1'b1;
              fail_code = ST_BAD_UNI;
            end else if (hex_count == 2'd3) begin
              push            = 1'b1;
              cmd.kind        = CMD_CP;
              cmd.data        = cp_shift;
              mode_next       = MODE_NORMAL;
              hex_count_next  = 2'd0;
              code_point_next = 16'd0;
            end else if (in_last) begin
              fail      = 1'b1;
              fail_code = ST_BAD_UNI;
            end else begin
              code_point_next = cp_shift;
              hex_count_next  = hex_count + 2'd1;
            end
          end
          default: begin
            mode_next = MODE_NORMAL;
            if (in_byte == 8'h5C) begin
              if (in_last) begin
                fail      = 1'b1;
                fail_code = ST_BAD_ESC;
              end else begin
                mode_next = MODE_ESCAPE;
              end
            end else begin
              push     = 1'b1;
              cmd.data = {8'd0, in_byte};
            end
          end
        endcase
        if (fail) begin
          mode_next       = MODE_NORMAL;
          hex_count_next  = 2'd0;
          code_point_next = 16'd0;
          discarding_next = !in_last;
          push            = 1'b1;
          cmd.kind        = CMD_ERR;
          cmd.data        = 16'd0;
          cmd.status      = fail_code;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_NORMAL;
      hex_count  <= 2'd0;
      code_point <= 16'd0;
      discarding <= 1'b0;
    end else begin
      mode       <= mode_next;
      hex_count  <= hex_count_next;
      code_point <= code_point_next;
      discarding <= discarding_next;
    end
  end

endmodule

// File: rtl/core/jsu_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_queue
// Short command queue between the parser and the byte emitter.
// ----------------------------------------------------------------------------
module jsu_queue
  import jsu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic empty,
  output logic full
);

  cmd_t           entries [QDEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QAW:0]   count;

  assign empty = (count == '0);
  assign full  = (count == (QAW+1)'(QDEPTH));
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (QAW+1)'(QDEPTH))
    else $error("queue count out of range");
  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (count == $past(count) - 1'b1))
    else $error("queue count did not drop on pop");

endmodule

// File: rtl/core/jsu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_back
// Byte emitter: expands each queued command into one to three output beats.
// ----------------------------------------------------------------------------
module jsu_back
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       head,
  input  logic       empty,
  output logic       pop,
  output logic       dn_valid,
  input  logic       dn_stall,
  output logic [7:0] out_byte,
  output logic [1:0] status,
  output logic       run_last,
  output logic       string_end
);

  logic [1:0] idx;
  logic [1:0] nbeats;
  logic       load;
  logic       final_beat;
  logic [7:0] beat_byte;

  assign load = !empty && (!dn_valid || !dn_stall);

  always_comb begin
    nbeats = 2'd1;
    if (head.kind == CMD_CP) begin
      if (head.data[15:7] == '0) begin
        nbeats = 2'd1;
      end else if (head.data[15:11] == '0) begin
        nbeats = 2'd2;
      end else begin
        nbeats = 2'd3;
      end
    end
  end

  assign final_beat = (idx == nbeats - 2'd1);
  assign pop        = load && final_beat;

  always_comb begin
    beat_byte = head.data[7:0];
    if (head.kind == CMD_CP) begin
      case (idx)
        2'd0: begin
          case (nbeats)
            2'd2:    beat_byte = {3'b110, head.data[10:6]};
            2'd3:    beat_byte = {4'b1110, head.data[15:12]};
            default: beat_byte = head.data[7:0];
          endcase
        end
        2'd1: begin
          if (nbeats == 2'd3) begin
            beat_byte = {2'b10, head.data[11:6]};
          end else begin
            beat_byte = {2'b10, head.data[5:0]};
          end
        end
        default: beat_byte = {2'b10, head.data[5:0]};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
      idx      <= 2'd0;
    end else begin
      if (load) begin
        dn_valid <= 1'b1;
        idx      <= final_beat ? 2'd0 : idx + 2'd1;
      end else if (!dn_stall) begin
        dn_valid <= 1'b0;
      end
    end
  end

  // hold the beat while stalled
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte   <= beat_byte;
      status     <= head.status;
      run_last   <= final_beat;
      string_end <= (head.kind == CMD_ERR) || (final_beat && head.last);
    end
  end

endmodule

// File: rtl/core/json_string_unescape_utf8_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_unit
// JSON string unescaper with UTF-8 output of \u escapes.
// ----------------------------------------------------------------------------
// A result beat is held in the command queue, then in the output register.
// Throughput: one input byte per cycle while the four-entry command queue has
// room; one output beat per cycle while dn_stall is low; \u gives up to 3 beats.
// Reset (rst, synchronous) clears parser state, queue pointers and output valid.
module json_string_unescape_utf8_unit
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       up_valid,
  output logic       up_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       dn_valid,
  input  logic       dn_stall,
  output logic [7:0] out_byte,
  output logic [1:0] status,
  output logic       run_last,
  output logic       string_end
);

  logic accept;
  logic push, pop, empty, full;
  cmd_t push_cmd, head;

  assign up_stall = full;
  assign accept   = up_valid && !full;

  jsu_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (in_byte),
    .in_last (in_last),
    .push    (push),
    .cmd     (push_cmd)
  );

  jsu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .dn_valid   (dn_valid),
    .dn_stall   (dn_stall),
    .out_byte   (out_byte),
    .status     (status),
    .run_last   (run_last),
    .string_end (string_end)
  );

endmodule

// File: verif/json_string_unescape_utf8_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_unit_tb
// Self-checking bench for the JSON string unescaper. A short table of directed
// bytes opens the run, and random escaped strings follow: plain text, simple
// escapes, \u escapes over the full code point range, and broken or truncated
// escapes. Most directed beats are checked against the table, the rest against
// an in-bench model of the parser and UTF-8 encoder. Handshakes idle at random.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_unit_tb;
  import jsu_pkg::*;

  localparam logic [7:0] BSLASH = 8'h5C;
  localparam logic [7:0] CH_U   = 8'h75;
  localparam int RANDOM_BYTES   = 320;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] status;
    logic       run_last;
    logic       string_end;
  } beat_t;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_NONE,
    ROW_ONE
  } row_kind_t;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
    row_kind_t  kind;
    beat_t      res;
  } row_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       up_valid;
  logic       up_stall;
  logic [7:0] in_byte;
  logic       in_last;
  logic       dn_valid;
  logic       dn_stall;
  logic [7:0] out_byte;
  logic [1:0] status;
  logic       run_last;
  logic       string_end;

  // parser state of the bench model
  mode_t       esc_mode;
  logic [1:0]  hex_cnt;
  logic [15:0] cp_acc;
  logic        dropping;

  beat_t      step_out[$];
  beat_t      unescaped_due[$];
  row_t       directed[$];
  logic [7:0] src_bytes[$];
  int         bad_beats = 0;
  int         bytes_taken = 0;
  logic       quiet = 1'b0;

  json_string_unescape_utf8_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (up_valid),
    .up_stall   (up_stall),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .dn_valid   (dn_valid),
    .dn_stall   (dn_stall),
    .out_byte   (out_byte),
    .status     (status),
    .run_last   (run_last),
    .string_end (string_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int nibble_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
    if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
    return -1;
  endfunction

  // {known, mapped byte} for the single-character escapes
  function automatic logic [8:0] simple_escape(input logic [7:0] c);
    case (c)
      8'h5C:   return {1'b1, 8'h5C};
      8'h22:   return {1'b1, 8'h22};
      8'h2F:   return {1'b1, 8'h2F};
      8'h62:   return {1'b1, 8'h08};
      8'h66:   return {1'b1, 8'h0C};
      8'h6E:   return {1'b1, 8'h0A};
      8'h72:   return {1'b1, 8'h0D};
      8'h74:   return {1'b1, 8'h09};
      default: return {1'b0, 8'h00};
    endcase
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input logic upper);
    if (n < 4'd10) return 8'h30 + n;
    return (upper ? 8'h41 : 8'h61) + (n - 4'd10);
  endfunction

  task automatic reject(input logic [1:0] code, input logic last);
    esc_mode = MODE_NORMAL;
    hex_cnt  = 2'd0;
    cp_acc   = 16'h0;
    dropping = !last;
    step_out.push_back({8'h00, code, 1'b1, 1'b1});
  endtask

  // Work out the beats that one accepted source byte gives.
  task automatic unescape_byte(input logic [7:0] b, input logic last);
    logic [8:0]  esc;
    logic [15:0] cp;
    int          v;
    step_out.delete();
    if (dropping) begin
      if (last) begin
        dropping = 1'b0;
        esc_mode = MODE_NORMAL;
        hex_cnt  = 2'd0;
        cp_acc   = 16'h0;
      end
    end else if (esc_mode == MODE_ESCAPE) begin
      esc = simple_escape(b);
      if (esc[8]) begin
        esc_mode = MODE_NORMAL;
        hex_cnt  = 2'd0;
        cp_acc   = 16'h0;
        step_out.push_back({esc[7:0], ST_OK, 1'b1, last});
      end else if (b == CH_U) begin
        if (last) begin
          reject(ST_BAD_UNI, last);
        end else begin
          esc_mode = MODE_HEX;
          hex_cnt  = 2'd0;
          cp_acc   = 16'h0;
        end
      end else begin
        reject(ST_BAD_ESC, last);
      end
    end else if (esc_mode == MODE_HEX) begin
      v = nibble_of(b);
      if (v < 0) begin
        reject(ST_BAD_UNI, last);
      end else begin
        cp_acc = {cp_acc[11:0], 4'(v)};
        if (hex_cnt == 2'd3) begin
          cp       = cp_acc;
          esc_mode = MODE_NORMAL;
          hex_cnt  = 2'd0;
          cp_acc   = 16'h0;
          if (cp <= 16'h007F) begin
            step_out.push_back({cp[7:0], ST_OK, 1'b1, last});
          end else if (cp <= 16'h07FF) begin
            step_out.push_back({8'hC0 | 8'(cp[10:6]), ST_OK, 1'b0, 1'b0});
            step_out.push_back({8'h80 | 8'(cp[5:0]), ST_OK, 1'b1, last});
          end else begin
            step_out.push_back({8'hE0 | 8'(cp[15:12]), ST_OK, 1'b0, 1'b0});
            step_out.push_back({8'h80 | 8'(cp[11:6]), ST_OK, 1'b0, 1'b0});
            step_out.push_back({8'h80 | 8'(cp[5:0]), ST_OK, 1'b1, last});
          end
        end else begin
          hex_cnt = hex_cnt + 2'd1;
          if (last) reject(ST_BAD_UNI, last);
        end
      end
    end else begin
      esc_mode = MODE_NORMAL;
      if (b == BSLASH) begin
        if (last) reject(ST_BAD_ESC, last);
        else esc_mode = MODE_ESCAPE;
      end else begin
        step_out.push_back({b, ST_OK, 1'b1, last});
      end
    end
  endtask

  // Offer one byte, hold it until taken, then book its beats.
  task automatic send_byte(input logic [7:0] b, input logic last, input row_kind_t kind,
                           input beat_t typed);
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < 8) begin
      up_valid <= 1'b0;
      @(negedge clk);
    end
    up_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= last;
    do @(posedge clk); while (up_stall);
    unescape_byte(b, last);
    if (kind == ROW_PREDICT) begin
      foreach (step_out[i]) unescaped_due.push_back(step_out[i]);
    end else if (kind == ROW_ONE) begin
      unescaped_due.push_back(typed);
    end
    bytes_taken++;
  endtask

  task automatic random_string();
    int          nseg;
    int          pick;
    int          ndig;
    logic [15:0] cp;
    logic [8:0]  esc;
    logic [7:0]  c;
    src_bytes.delete();
    nseg = $urandom_range(1, 6);
    repeat (nseg) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        repeat ($urandom_range(1, 4)) src_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 55) begin
        do begin
          c   = 8'($urandom_range(0, 255));
          esc = simple_escape(c);
        end while (!esc[8]);
        src_bytes.push_back(BSLASH);
        src_bytes.push_back(c);
      end else if (pick < 85) begin
        case ($urandom_range(0, 5))
          0: cp = 16'($urandom_range(0, 16'h007F));
          1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
          2: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
          3: cp = 16'($urandom_range(16'hD800, 16'hDFFF));
          4: begin
            case ($urandom_range(0, 5))
              0: cp = 16'h0000;
              1: cp = 16'h007F;
              2: cp = 16'h0080;
              3: cp = 16'h07FF;
              4: cp = 16'h0800;
              default: cp = 16'hFFFF;
            endcase
          end
          default: cp = 16'($urandom_range(0, 16'hFFFF));
        endcase
        src_bytes.push_back(BSLASH);
        src_bytes.push_back(CH_U);
        for (int k = 3; k >= 0; k--)
          src_bytes.push_back(hex_char(cp[4*k +: 4], 1'($urandom_range(0, 1))));
      end else if (pick < 93) begin
        // unknown escape character
        do begin
          c   = 8'($urandom_range(0, 255));
          esc = simple_escape(c);
        end while (esc[8] || c == CH_U);
        src_bytes.push_back(BSLASH);
        src_bytes.push_back(c);
      end else begin
        // \u broken by a non-hex byte
        src_bytes.push_back(BSLASH);
        src_bytes.push_back(CH_U);
        ndig = $urandom_range(0, 3);
        repeat (ndig) src_bytes.push_back(hex_char(4'($urandom_range(0, 15)), 1'b0));
        do c = 8'($urandom_range(0, 255)); while (nibble_of(c) >= 0);
        src_bytes.push_back(c);
      end
    end
    // cut some strings short, at times in mid-escape
    if ($urandom_range(0, 9) == 0) begin
      pick = $urandom_range(1, src_bytes.size());
      while (src_bytes.size() > pick) void'(src_bytes.pop_back());
    end
    foreach (src_bytes[i])
      send_byte(src_bytes[i], i == src_bytes.size() - 1, ROW_PREDICT, '0);
  endtask

  always @(negedge clk) begin
    dn_stall <= !quiet && ($urandom_range(0, 99) < 8);
  end

  always @(posedge clk) begin
    beat_t want;
    if (!rst && dn_valid && !dn_stall) begin
      if (unescaped_due.size() == 0) begin
        $error("out_byte: expected no beat, got %0h", out_byte);
        bad_beats++;
      end else begin
        want = unescaped_due.pop_front();
        if (out_byte !== want.data) begin
          $error("out_byte: expected %0h, got %0h", want.data, out_byte);
          bad_beats++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          bad_beats++;
        end
        if (run_last !== want.run_last) begin
          $error("run_last: expected %0b, got %0b", want.run_last, run_last);
          bad_beats++;
        end
        if (string_end !== want.string_end) begin
          $error("string_end: expected %0b, got %0b", want.string_end, string_end);
          bad_beats++;
        end
      end
    end
  end

  initial begin
    rst      = 1'b1;
    up_valid = 1'b0;
    in_byte  = 8'h00;
    in_last  = 1'b0;
    dn_stall = 1'b0;
    esc_mode = MODE_NORMAL;
    hex_cnt  = 2'd0;
    cp_acc   = 16'h0;
    dropping = 1'b0;

    // byte, last, kind, {out_byte, status, run_last, string_end}
    directed.push_back({8'h00, 1'b0, ROW_ONE,     8'h00, ST_OK,      1'b1, 1'b0});
    directed.push_back({8'hFF, 1'b0, ROW_ONE,     8'hFF, ST_OK,      1'b1, 1'b0});
    directed.push_back({BSLASH, 1'b0, ROW_NONE,   12'h000});
    directed.push_back({BSLASH, 1'b0, ROW_ONE,    BSLASH, ST_OK,     1'b1, 1'b0});
    directed.push_back({BSLASH, 1'b0, ROW_NONE,   12'h000});
    directed.push_back({8'h74, 1'b0, ROW_ONE,     8'h09, ST_OK,      1'b1, 1'b0});
    directed.push_back({BSLASH, 1'b0, ROW_NONE,   12'h000});
    directed.push_back({CH_U,  1'b0, ROW_NONE,    12'h000});
    directed.push_back({8'h46, 1'b0, ROW_NONE,    12'h000});
    directed.push_back({8'h66, 1'b0, ROW_NONE,    12'h000});
    directed.push_back({8'h46, 1'b0, ROW_NONE,    12'h000});
    directed.push_back({8'h66, 1'b0, ROW_PREDICT, 12'h000});
    directed.push_back({BSLASH, 1'b0, ROW_NONE,   12'h000});
    directed.push_back({CH_U,  1'b0, ROW_NONE,    12'h000});
    directed.push_back({8'h30, 1'b0, ROW_NONE,    12'h000});
    directed.push_back({8'h30, 1'b0, ROW_NONE,    12'h000});
    directed.push_back({8'h30, 1'b0, ROW_NONE,    12'h000});
    directed.push_back({8'h30, 1'b1, ROW_ONE,     8'h00, ST_OK,      1'b1, 1'b1});
    directed.push_back({BSLASH, 1'b0, ROW_NONE,   12'h000});
    directed.push_back({8'h78, 1'b0, ROW_ONE,     8'h00, ST_BAD_ESC, 1'b1, 1'b1});
    directed.push_back({8'h71, 1'b1, ROW_NONE,    12'h000});
    directed.push_back({BSLASH, 1'b1, ROW_ONE,    8'h00, ST_BAD_ESC, 1'b1, 1'b1});
    directed.push_back({BSLASH, 1'b0, ROW_NONE,   12'h000});
    directed.push_back({CH_U,  1'b1, ROW_ONE,     8'h00, ST_BAD_UNI, 1'b1, 1'b1});
    directed.push_back({BSLASH, 1'b0, ROW_NONE,   12'h000});
    directed.push_back({CH_U,  1'b0, ROW_NONE,    12'h000});
    directed.push_back({8'h67, 1'b0, ROW_ONE,     8'h00, ST_BAD_UNI, 1'b1, 1'b1});
    directed.push_back({8'h00, 1'b1, ROW_NONE,    12'h000});

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i])
      send_byte(directed[i].b, directed[i].last, directed[i].kind, directed[i].res);

    bytes_taken = 0;
    while (bytes_taken < RANDOM_BYTES) begin
      // hold both sides busy for a long stretch mid-run
      quiet = bytes_taken >= 120 && bytes_taken < 220;
      random_string();
    end
    quiet = 1'b0;

    @(negedge clk);
    up_valid <= 1'b0;
    while (unescaped_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (bad_beats == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
